@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion shorthands for the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// rpn_pkg
// types and constants of the postfix expression evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

    // datapath widths
    localparam int DATA_W    = 32;
    localparam int TOK_W     = 8;
    localparam int DIV_CNT_W = 5;

    // token codes
    localparam logic [TOK_W-1:0] TOK_ADD  = 8'h2B;
    localparam logic [TOK_W-1:0] TOK_SUB  = 8'h2D;
    localparam logic [TOK_W-1:0] TOK_MUL  = 8'h2A;
    localparam logic [TOK_W-1:0] TOK_DIV  = 8'h2F;
    localparam logic [TOK_W-1:0] TOK_ZERO = 8'h30;

    // expression status, first error wins
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_L,
        S_EXEC,
        S_DIV,
        S_PUSH,
        S_FINAL,
        S_OUT_LOAD
    } t_state;

endpackage

`default_nettype wire

@@ src/postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// evaluates a postfix expression streamed one character per transaction,
// operand stack in a local memory, shared alu plus radix-2 divider
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------
//  input   | in        | i_valid / o_ready  | i_token[7:0], i_last
//  result  | out       | o_valid / i_ready  | o_value[31:0], o_status[1:0]
//
//  states per transaction: push via decode, push; + - * via decode, pop_l, exec, push;
//  / adds 32 divider steps before push, none on a zero divisor; a transaction with
//  i_last adds the final pop and result load, the load held while the previous result
//  waits in the output register; stack reads use the registered memory read port
//  reset clears sequencer, stack pointer, status and result valid, not the stack
//  a waiting result holds up the next result load and, with it, the input side
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module postfix_expression_evaluator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [TOK_W-1:0]         i_token,
    input  wire logic                     i_last,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [DATA_W-1:0]      o_value,
    output logic [1:0]                    o_status
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // control state
    t_state                r_state, n_state;
    logic [SP_W-1:0]       r_sp, n_sp;
    t_status               r_err, n_err;
    logic                  r_out_valid, n_out_valid;

    // payload registers
    logic [TOK_W-1:0]      r_tok;
    logic                  r_last;
    logic [DATA_W-1:0]     r_rhs, n_rhs;
    logic [DATA_W-1:0]     r_res, n_res;
    logic                  r_pop_ok, n_pop_ok;
    logic [DATA_W-1:0]     r_rd_data;
    logic [DATA_W-1:0]     r_out_value, n_out_value;
    t_status               r_out_status, n_out_status;

    // divider registers
    logic [DATA_W-1:0]     r_quo, n_quo;
    logic [DATA_W-1:0]     r_rem, n_rem;
    logic [DATA_W-1:0]     r_den, n_den;
    logic                  r_neg, n_neg;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;

    // stack memory
    logic [DATA_W-1:0]     r_mem [STACK_DEPTH];
    logic                  w_mem_we;
    logic                  w_mem_re;

    logic                  w_in_acc;
    logic                  w_is_op;
    logic                  w_sp_nz;
    logic                  w_sp_full;
    logic [SP_W-1:0]       w_sp_dec;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_W-1:0]     w_popped;
    logic                  w_out_free;
    logic [DATA_W:0]       w_div_shift;
    logic [DATA_W:0]       w_div_diff;
    logic [DATA_W-1:0]     w_quo_step;
    logic [DATA_W-1:0]     w_rem_step;

    // handshake and decode
    assign o_ready    = (r_state == S_IDLE);
    assign w_in_acc   = i_valid && o_ready;
    assign w_is_op    = (r_tok == TOK_ADD) || (r_tok == TOK_SUB) ||
                        (r_tok == TOK_MUL) || (r_tok == TOK_DIV);
    assign w_sp_nz    = (r_sp != '0);
    assign w_sp_full  = (r_sp == SP_W'(STACK_DEPTH));
    assign w_sp_dec   = r_sp - SP_W'(1);
    assign w_rd_addr  = w_sp_dec[AW-1:0];
    assign w_wr_addr  = r_sp[AW-1:0];
    assign w_popped   = r_pop_ok ? r_rd_data : '0;
    assign w_out_free = !r_out_valid || i_ready;

    // one restoring divider step on magnitudes
    assign w_div_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_div_diff  = w_div_shift - {1'b0, r_den};
    assign w_quo_step  = {r_quo[DATA_W-2:0], ~w_div_diff[DATA_W]};
    assign w_rem_step  = w_div_diff[DATA_W] ? w_div_shift[DATA_W-1:0]
                                            : w_div_diff[DATA_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_in_acc) n_state = S_DECODE;
            S_DECODE:   n_state = w_is_op ? S_POP_L : S_PUSH;
            S_POP_L:    n_state = S_EXEC;
            S_EXEC: begin
                if (r_tok == TOK_DIV && r_rhs != '0) n_state = S_DIV;
                else                                 n_state = S_PUSH;
            end
            S_DIV:      if (r_cnt == '0) n_state = S_PUSH;
            S_PUSH:     n_state = r_last ? S_FINAL : S_IDLE;
            S_FINAL:    n_state = S_OUT_LOAD;
            S_OUT_LOAD: if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and stack control
    always_comb begin
        n_sp         = r_sp;
        n_err        = r_err;
        n_rhs        = r_rhs;
        n_res        = r_res;
        n_pop_ok     = r_pop_ok;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_den        = r_den;
        n_neg        = r_neg;
        n_cnt        = r_cnt;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_valid  = r_out_valid && !i_ready;
        w_mem_we     = 1'b0;
        w_mem_re     = 1'b0;

        case (r_state)
            // right operand pop, or conversion of a literal digit
            S_DECODE: begin
                if (w_is_op) begin
                    n_pop_ok = w_sp_nz;
                    if (w_sp_nz) begin
                        w_mem_re = 1'b1;
                        n_sp     = w_sp_dec;
                    end else if (r_err == ST_OK) begin
                        n_err = ST_UNDER;
                    end
                end else begin
                    n_res = DATA_W'(r_tok) - DATA_W'(TOK_ZERO);
                end
            end
            // capture right operand, pop left operand
            S_POP_L: begin
                n_rhs    = w_popped;
                n_pop_ok = w_sp_nz;
                if (w_sp_nz) begin
                    w_mem_re = 1'b1;
                    n_sp     = w_sp_dec;
                end else if (r_err == ST_OK) begin
                    n_err = ST_UNDER;
                end
            end
            // alu operation or divider load
            S_EXEC: begin
                case (r_tok)
                    TOK_ADD: n_res = w_popped + r_rhs;
                    TOK_SUB: n_res = w_popped - r_rhs;
                    TOK_MUL: n_res = w_popped * r_rhs;
                    TOK_DIV: begin
                        if (r_rhs == '0) begin
                            n_res = '0;
                            if (r_err == ST_OK) n_err = ST_DIVZ;
                        end else begin
                            n_quo = w_popped[DATA_W-1] ? -w_popped : w_popped;
                            n_den = r_rhs[DATA_W-1] ? -r_rhs : r_rhs;
                            n_rem = '0;
                            n_neg = w_popped[DATA_W-1] ^ r_rhs[DATA_W-1];
                            n_cnt = '1;
                        end
                    end
                    default: n_res = r_res;
                endcase
            end
            // one quotient bit per cycle
            S_DIV: begin
                n_quo = w_quo_step;
                n_rem = w_rem_step;
                n_cnt = r_cnt - DIV_CNT_W'(1);
                if (r_cnt == '0) n_res = r_neg ? -w_quo_step : w_quo_step;
            end
            // push result, drop it when the stack is full
            S_PUSH: begin
                if (w_sp_full) begin
                    if (r_err == ST_OK) n_err = ST_OVER;
                end else begin
                    w_mem_we = 1'b1;
                    n_sp     = r_sp + SP_W'(1);
                end
            end
            // final pop of the expression value
            S_FINAL: begin
                n_pop_ok = w_sp_nz;
                if (w_sp_nz) begin
                    w_mem_re = 1'b1;
                    n_sp     = w_sp_dec;
                end else if (r_err == ST_OK) begin
                    n_err = ST_UNDER;
                end
            end
            // load result register, clear expression state
            S_OUT_LOAD: begin
                if (w_out_free) begin
                    n_out_value  = w_popped;
                    n_out_status = r_err;
                    n_out_valid  = 1'b1;
                    n_sp         = '0;
                    n_err        = ST_OK;
                end
            end
            default: begin
                n_sp = r_sp;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_tok  <= i_token;
            r_last <= i_last;
        end
        r_rhs        <= n_rhs;
        r_res        <= n_res;
        r_pop_ok     <= n_pop_ok;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_den        <= n_den;
        r_neg        <= n_neg;
        r_cnt        <= n_cnt;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    // operand stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_wr_addr] <= r_res;
        if (w_mem_re) r_rd_data <= r_mem[w_rd_addr];
    end

    assign o_valid  = r_out_valid;
    assign o_value  = signed'(r_out_value);
    assign o_status = r_out_status;

    // checks
    `ASSERT_ALWAYS(a_sp_range, i_clk, i_rst_n, r_sp <= SP_W'(STACK_DEPTH),
        "stack pointer beyond depth")
    `ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, w_in_acc, r_state == S_DECODE,
        "accepted transaction not decoded")
    `ASSERT_NEXT(a_overflow_flag, i_clk, i_rst_n, r_state == S_PUSH && w_sp_full,
        r_err != ST_OK, "push on full stack left no error")
    `ASSERT_SAME(a_load_clears, i_clk, i_rst_n, $rose(r_out_valid),
        r_sp == '0 && r_err == ST_OK, "result load did not clear expression state")

endmodule

`default_nettype wire
